// ----- sv/ksp_pkg.sv -----
// ksp_pkg: shared constants, knight move table and the distance bound
// for the knight shortest path search; no dependencies
package ksp_pkg;

   localparam int unsigned DIST_W = 14;
   localparam logic [DIST_W-1:0] DIST_MAX = 14'h3fff;
   localparam int unsigned EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST = 8'hff;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'h01;
   localparam int unsigned MOVE_COUNT = 8;

   typedef logic signed [2:0] offset_type;

   // row offset of knight move k
   function automatic offset_type move_dr(input logic [2:0] k);
      case (k)
         3'd0, 3'd1: move_dr = 3'sd2;
         3'd2, 3'd3: move_dr = -3'sd2;
         3'd4, 3'd6: move_dr = 3'sd1;
         default:    move_dr = -3'sd1;
      endcase
   endfunction

   // column offset of knight move k
   function automatic offset_type move_dc(input logic [2:0] k);
      case (k)
         3'd0, 3'd2: move_dc = 3'sd1;
         3'd1, 3'd3: move_dc = -3'sd1;
         3'd4, 3'd5: move_dc = 3'sd2;
         default:    move_dc = -3'sd2;
      endcase
   endfunction

endpackage

// ----- sv/ksp_if.sv -----
// ksp_req_if / ksp_rsp_if: valid-ready channels for queries and results
// depends on nothing
interface ksp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] board_rows;
   logic [7:0] board_cols;
   logic [6:0] start_row;
   logic [6:0] start_col;
   logic [6:0] target_row;
   logic [6:0] target_col;

   modport source (output valid, board_rows, board_cols, start_row, start_col,
                   target_row, target_col, input ready);
   modport sink (input valid, board_rows, board_cols, start_row, start_col,
                 target_row, target_col, output ready);
endinterface

interface ksp_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] move_count;
   logic        reachable;

   modport source (output valid, move_count, reachable, input ready);
   modport sink (input valid, move_count, reachable, output ready);
endinterface

// ----- sv/ksp_ram.sv -----
// ksp_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ksp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/knight_shortest_path_bfs.sv -----
// knight_shortest_path_bfs: top level of the knight shortest path search
// depends on ksp_pkg, ksp_if (ksp_req_if, ksp_rsp_if) and ksp_ram
//
// usage
// - req_bus carries one query per transaction: board size, start and target cell
// - rsp_bus returns one transaction per query: move_count and reachable
// - a query off the board, or with start equal to target, goes straight to the finish step
// - otherwise breadth-first search: each dequeued cell takes one frontier read,
//   eight move probes and one drain step, the probes one at a time through the
//   single read port of the seen map
// - the search stops as soon as the target is first marked
// - seen map holds an epoch tag per cell; a cell is seen when its tag equals
//   the current epoch, so no per-query clear is needed
// - after reset, and after every 255 queries of any kind, a clearing pass writes
//   all 2^(2*clog2(MAX_DIM)) entries (16384 entries at MAX_DIM 128); req_bus.ready
//   stays low meanwhile
// - the result sits in an output register; a stalled receiver holds the block in
//   its finish step, and the next query is taken once the result is loaded
// - reset is synchronous active high and clears all control state
module knight_shortest_path_bfs #(
   parameter int MAX_DIM = 128
) (
   input  logic      clock,
   input  logic      reset,
   ksp_req_if.sink   req_bus,
   ksp_rsp_if.source rsp_bus
);
   localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int AW    = 2 * CW;
   localparam int CELLS = 1 << AW;
   localparam int RDW   = CW + 1;
   localparam int PW    = AW + 1;
   localparam int DW    = ksp_pkg::DIST_W;
   localparam int EW    = ksp_pkg::EPOCH_W;
   localparam int FW    = AW + DW;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_FETCH, S_SCAN, S_DRAIN, S_FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [EW-1:0]   epoch_ff, epoch_in;
   logic [RDW-1:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic [AW-1:0]   tgt_ff, tgt_in;
   logic [PW-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [2:0]      k_ff, k_in;
   logic            chk_valid_ff, chk_valid_in;
   logic [AW-1:0]   chk_cell_ff, chk_cell_in;
   logic [DW-1:0]   res_dist_ff, res_dist_in;
   logic            res_reach_ff, res_reach_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]   rsp_dist_ff, rsp_dist_in;
   logic            rsp_reach_ff, rsp_reach_in;

   // memory ports
   logic            map_we, map_re;
   logic [AW-1:0]   map_waddr, map_raddr;
   logic [EW-1:0]   map_wdata, map_rdata;
   logic            fifo_we, fifo_re;
   logic [AW-1:0]   fifo_waddr, fifo_raddr;
   logic [FW-1:0]   fifo_wdata, fifo_rdata;

   // query decode
   logic [RDW-1:0]  q_rows, q_cols;
   logic            q_ok;
   logic [AW-1:0]   q_start, q_target;

   // expansion of the current cell
   logic [AW-1:0]          cur_cell;
   logic [CW-1:0]          cur_row, cur_col;
   logic [DW-1:0]          cur_dist, next_dist;
   logic signed [CW+1:0]   nr, nc;
   logic                   in_bounds;
   logic                   hit_new, found;

   ksp_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_seen_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (map_re),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   ksp_ram #(.WIDTH(FW), .DEPTH(CELLS)) u_frontier (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_waddr),
      .wr_data (fifo_wdata),
      .rd_en   (fifo_re),
      .rd_addr (fifo_raddr),
      .rd_data (fifo_rdata)
   );

   // saturate board size and check both cells lie on the board
   always_comb begin
      if ({3'b000, req_bus.board_rows} > 11'(MAX_DIM)) q_rows = RDW'(MAX_DIM);
      else q_rows = RDW'(req_bus.board_rows);
      if ({3'b000, req_bus.board_cols} > 11'(MAX_DIM)) q_cols = RDW'(MAX_DIM);
      else q_cols = RDW'(req_bus.board_cols);
      q_ok = (11'(req_bus.start_row) < 11'(q_rows)) &&
             (11'(req_bus.start_col) < 11'(q_cols)) &&
             (11'(req_bus.target_row) < 11'(q_rows)) &&
             (11'(req_bus.target_col) < 11'(q_cols));
      q_start  = {CW'(req_bus.start_row), CW'(req_bus.start_col)};
      q_target = {CW'(req_bus.target_row), CW'(req_bus.target_col)};
   end

   // frontier entry holds the cell and its distance
   assign cur_cell  = fifo_rdata[FW-1:DW];
   assign cur_dist  = fifo_rdata[DW-1:0];
   assign cur_row   = cur_cell[AW-1:CW];
   assign cur_col   = cur_cell[CW-1:0];
   assign next_dist = (cur_dist == ksp_pkg::DIST_MAX) ? cur_dist : cur_dist + 1'b1;

   // neighbor for move k
   always_comb begin
      nr = $signed({2'b00, cur_row}) + (CW+2)'(ksp_pkg::move_dr(k_ff));
      nc = $signed({2'b00, cur_col}) + (CW+2)'(ksp_pkg::move_dc(k_ff));
      in_bounds = !nr[CW+1] && !nc[CW+1] &&
                  (nr[CW:0] < rows_ff) && (nc[CW:0] < cols_ff);
   end

   // probe result from last cycle: neighbor not yet seen in this epoch
   assign hit_new = chk_valid_ff && (map_rdata != epoch_ff) &&
                    ((state_ff == S_SCAN) || (state_ff == S_DRAIN));
   assign found   = hit_new && (chk_cell_ff == tgt_ff);

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.move_count = rsp_dist_ff;
   assign rsp_bus.reachable  = rsp_reach_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      epoch_in     = epoch_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      tgt_in       = tgt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      k_in         = k_ff;
      chk_valid_in = 1'b0;
      chk_cell_in  = {CW'(nr[CW-1:0]), CW'(nc[CW-1:0])};
      res_dist_in  = res_dist_ff;
      res_reach_in = res_reach_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_reach_in = rsp_reach_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      map_we     = 1'b0;
      map_waddr  = chk_cell_ff;
      map_wdata  = epoch_ff;
      map_re     = 1'b0;
      map_raddr  = chk_cell_in;
      fifo_we    = 1'b0;
      fifo_waddr = tail_ff[AW-1:0];
      fifo_wdata = {chk_cell_ff, next_dist};
      fifo_re    = 1'b0;
      fifo_raddr = head_ff[AW-1:0];

      // newly seen neighbor: mark it and enqueue it
      if (hit_new) begin
         map_we  = 1'b1;
         fifo_we = 1'b1;
         tail_in = tail_ff + 1'b1;
      end

      case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(CELLS - 1)) begin
               epoch_in = ksp_pkg::EPOCH_FIRST;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               rows_in = q_rows;
               cols_in = q_cols;
               tgt_in  = q_target;
               if (!q_ok) begin
                  res_dist_in  = '0;
                  res_reach_in = 1'b0;
                  state_in     = S_FINISH;
               end else if (q_start == q_target) begin
                  res_dist_in  = '0;
                  res_reach_in = 1'b1;
                  state_in     = S_FINISH;
               end else begin
                  // seed the search with the start cell
                  map_we     = 1'b1;
                  map_waddr  = q_start;
                  map_wdata  = epoch_ff;
                  fifo_we    = 1'b1;
                  fifo_waddr = '0;
                  fifo_wdata = {q_start, {DW{1'b0}}};
                  head_in    = '0;
                  tail_in    = PW'(1);
                  state_in   = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            fifo_re  = 1'b1;
            head_in  = head_ff + 1'b1;
            k_in     = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (found) begin
               res_dist_in  = next_dist;
               res_reach_in = 1'b1;
               state_in     = S_FINISH;
            end else begin
               map_re       = in_bounds;
               chk_valid_in = in_bounds;
               k_in         = k_ff + 1'b1;
               if (k_ff == 3'(ksp_pkg::MOVE_COUNT - 1)) state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (found) begin
               res_dist_in  = next_dist;
               res_reach_in = 1'b1;
               state_in     = S_FINISH;
            end else if (head_ff == tail_in) begin
               res_dist_in  = '0;
               res_reach_in = 1'b0;
               state_in     = S_FINISH;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = res_dist_ff;
               rsp_reach_in = res_reach_ff;
               // retire the epoch; sweep the map when tags run out
               if (epoch_ff == ksp_pkg::EPOCH_LAST) begin
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         epoch_ff     <= ksp_pkg::EPOCH_FIRST;
         head_ff      <= '0;
         tail_ff      <= '0;
         k_ff         <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         epoch_ff     <= epoch_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         k_ff         <= k_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rows_ff      <= rows_in;
      cols_ff      <= cols_in;
      tgt_ff       <= tgt_in;
      chk_cell_ff  <= chk_cell_in;
      res_dist_ff  <= res_dist_in;
      res_reach_ff <= res_reach_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_reach_ff <= rsp_reach_in;
   end

endmodule

// ----- verif/tb_knight_shortest_path_bfs.sv -----
`timescale 1ns / 1ps
// tb_knight_shortest_path_bfs: self-checking bench for the knight shortest path search
// depends on ksp_pkg, ksp_if and the knight_shortest_path_bfs rtl
module tb_knight_shortest_path_bfs;

   localparam int DIM = 128;
   // longest silent stretch: a full-board search plus a clearing pass, with margin
   localparam int IDLE_LIMIT = 600000;
   localparam int N_DIRECTED = 22;
   localparam int N_RANDOM = 80;

   typedef struct packed {
      logic [7:0] rows;
      logic [7:0] cols;
      logic [6:0] sr;
      logic [6:0] sc;
      logic [6:0] tr;
      logic [6:0] tc;
   } query_type;

   typedef struct packed {
      logic [13:0] moves;
      logic        reach;
   } answer_type;

   // one directed row: query, whether the answer is typed in, and that answer
   typedef struct packed {
      query_type  q;
      logic       fixed;
      answer_type a;
   } stim_row_type;

   logic clock;
   logic reset;

   ksp_req_if req_bus ();
   ksp_rsp_if rsp_bus ();

   knight_shortest_path_bfs #(.MAX_DIM(DIM)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   // expected answers, oldest first
   answer_type answer_queue[$];
   int      error_count;
   int      answers_seen;
   int      reach_seen;
   int      idle_cycles;
   bit      quiet_phase;
   bit      stim_done;

   // scratch for the predictor
   bit          visited[DIM*DIM];
   logic [13:0] hops[DIM*DIM];
   int          frontier[DIM*DIM];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // breadth-first search over the board, stopping at the first hit on the target
   function automatic answer_type knight_distance(input query_type q);
      int      rows;
      int      cols;
      int      head;
      int      tail;
      int      cur;
      int      nr;
      int      nc;
      int      nxt;
      int      tgt;
      bit      found;
      answer_type a;
      rows = (q.rows > DIM) ? DIM : q.rows;
      cols = (q.cols > DIM) ? DIM : q.cols;
      a = '0;
      if (q.sr >= rows || q.sc >= cols || q.tr >= rows || q.tc >= cols) begin
         return a;
      end
      foreach (visited[i]) visited[i] = 1'b0;
      tgt = q.tr * DIM + q.tc;
      cur = q.sr * DIM + q.sc;
      visited[cur] = 1'b1;
      hops[cur] = '0;
      frontier[0] = cur;
      head = 0;
      tail = 1;
      found = (cur == tgt);
      while (!found && head < tail) begin
         cur = frontier[head];
         head++;
         for (int k = 0; k < 8 && !found; k++) begin
            nr = cur / DIM + ksp_pkg::move_dr(3'(k));
            nc = cur % DIM + ksp_pkg::move_dc(3'(k));
            if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
            nxt = nr * DIM + nc;
            if (visited[nxt]) continue;
            visited[nxt] = 1'b1;
            hops[nxt] = (hops[cur] < ksp_pkg::DIST_MAX) ? hops[cur] + 14'd1
                                                         : ksp_pkg::DIST_MAX;
            frontier[tail] = nxt;
            tail++;
            if (nxt == tgt) found = 1'b1;
         end
      end
      if (visited[tgt]) begin
         a.moves = hops[tgt];
         a.reach = 1'b1;
      end
      return a;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on answer %0d: %s got %0d expected %0d",
               answers_seen, what, got, want);
      error_count++;
   endtask

   // mostly small boards with in-range cells, a few big ones, some off-board noise
   function automatic query_type random_query();
      query_type q;
      int     pick;
      pick = $urandom_range(0, 99);
      q.rows = 8'($urandom);
      q.cols = 8'($urandom);
      if (pick < 75) begin
         q.rows = 8'($urandom_range(1, 12));
         q.cols = 8'($urandom_range(1, 12));
      end else if (pick < 80) begin
         q.rows = 8'($urandom_range(100, 255));
         q.cols = 8'($urandom_range(100, 255));
      end
      q.sr = 7'($urandom);
      q.sc = 7'($urandom);
      q.tr = 7'($urandom);
      q.tc = 7'($urandom);
      if (pick < 90) begin
         q.sr = 7'($urandom_range(0, (q.rows > DIM ? DIM : q.rows) - 1 + (q.rows == 0)));
         q.sc = 7'($urandom_range(0, (q.cols > DIM ? DIM : q.cols) - 1 + (q.cols == 0)));
         q.tr = 7'($urandom_range(0, (q.rows > DIM ? DIM : q.rows) - 1 + (q.rows == 0)));
         q.tc = 7'($urandom_range(0, (q.cols > DIM ? DIM : q.cols) - 1 + (q.cols == 0)));
      end
      return q;
   endfunction

   // send one query: queue its expected answer when the transaction completes
   task automatic send_query(input query_type q, input bit fixed, input answer_type a);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.board_rows <= q.rows;
      req_bus.board_cols <= q.cols;
      req_bus.start_row  <= q.sr;
      req_bus.start_col  <= q.sc;
      req_bus.target_row <= q.tr;
      req_bus.target_col <= q.tc;
      do @(posedge clock); while (!(req_bus.ready === 1'b1));
      answer_queue.push_back(fixed ? a : knight_distance(q));
   endtask

   // directed rows: typed-in answers for trivial cases, the predictor for the rest
   stim_row_type directed[N_DIRECTED] = '{
      '{q: '{8'd1,   8'd1,   7'd0,   7'd0,   7'd0,   7'd0},   fixed: 1, a: '{14'd0, 1'b1}},
      '{q: '{8'd0,   8'd5,   7'd0,   7'd0,   7'd0,   7'd0},   fixed: 1, a: '{14'd0, 1'b0}},
      '{q: '{8'd5,   8'd0,   7'd0,   7'd0,   7'd0,   7'd0},   fixed: 1, a: '{14'd0, 1'b0}},
      '{q: '{8'd8,   8'd8,   7'd8,   7'd0,   7'd0,   7'd0},   fixed: 1, a: '{14'd0, 1'b0}},
      '{q: '{8'd8,   8'd8,   7'd0,   7'd0,   7'd0,   7'd8},   fixed: 1, a: '{14'd0, 1'b0}},
      '{q: '{8'd8,   8'd8,   7'd127, 7'd127, 7'd0,   7'd0},   fixed: 1, a: '{14'd0, 1'b0}},
      '{q: '{8'd255, 8'd255, 7'd127, 7'd127, 7'd127, 7'd127}, fixed: 1, a: '{14'd0, 1'b1}},
      '{q: '{8'd8,   8'd8,   7'd0,   7'd0,   7'd2,   7'd1},   fixed: 1, a: '{14'd1, 1'b1}},
      '{q: '{8'd8,   8'd8,   7'd0,   7'd0,   7'd7,   7'd7},   fixed: 0, a: '0},
      '{q: '{8'd3,   8'd3,   7'd0,   7'd0,   7'd1,   7'd1},   fixed: 1, a: '{14'd0, 1'b0}},
      '{q: '{8'd2,   8'd2,   7'd0,   7'd0,   7'd1,   7'd1},   fixed: 1, a: '{14'd0, 1'b0}},
      '{q: '{8'd1,   8'd128, 7'd0,   7'd0,   7'd0,   7'd127}, fixed: 1, a: '{14'd0, 1'b0}},
      '{q: '{8'd3,   8'd4,   7'd0,   7'd0,   7'd2,   7'd3},   fixed: 0, a: '0},
      '{q: '{8'd4,   8'd4,   7'd3,   7'd3,   7'd0,   7'd0},   fixed: 0, a: '0},
      '{q: '{8'd128, 8'd128, 7'd0,   7'd0,   7'd127, 7'd127}, fixed: 0, a: '0},
      '{q: '{8'd200, 8'd129, 7'd127, 7'd0,   7'd0,   7'd127}, fixed: 0, a: '0},
      '{q: '{8'd128, 8'd128, 7'd0,   7'd0,   7'd1,   7'd1},   fixed: 0, a: '0},
      '{q: '{8'd5,   8'd9,   7'd4,   7'd8,   7'd0,   7'd0},   fixed: 0, a: '0},
      '{q: '{8'd7,   8'd3,   7'd6,   7'd2,   7'd0,   7'd1},   fixed: 0, a: '0},
      '{q: '{8'd127, 8'd2,   7'd0,   7'd0,   7'd126, 7'd1},   fixed: 0, a: '0},
      '{q: '{8'd10,  8'd10,  7'd5,   7'd5,   7'd85,  7'd42},  fixed: 1, a: '{14'd0, 1'b0}},
      '{q: '{8'd6,   8'd6,   7'd0,   7'd5,   7'd5,   7'd0},   fixed: 0, a: '0}
   };

   // stimulus
   initial begin
      reset = 1'b1;
      quiet_phase = 1'b0;
      stim_done = 1'b0;
      req_bus.valid <= 1'b0;
      req_bus.board_rows <= '0;
      req_bus.board_cols <= '0;
      req_bus.start_row <= '0;
      req_bus.start_col <= '0;
      req_bus.target_row <= '0;
      req_bus.target_col <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_query(directed[i].q, directed[i].fixed, directed[i].a);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i >= N_RANDOM - 15) quiet_phase = 1'b1;
         send_query(random_query(), 1'b0, '0);
      end
      req_bus.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // result side: random stalls and checking against the oldest expectation
   initial begin
      answer_type want;
      rsp_bus.ready <= 1'b0;
      error_count = 0;
      answers_seen = 0;
      reach_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (answer_queue.size() == 0) begin
               $display("unexpected answer %0d with no query waiting", answers_seen);
               error_count++;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_bus.move_count !== want.moves)
                  report_mismatch("move_count", rsp_bus.move_count, want.moves);
               if (rsp_bus.reachable !== want.reach)
                  report_mismatch("reachable", rsp_bus.reachable, want.reach);
               reach_seen += want.reach;
            end
            answers_seen++;
         end
         // random stall bursts, none near the end
         if (reset || quiet_phase || $urandom_range(0, 3) != 0) rsp_bus.ready <= 1'b1;
         else begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end
      end
   end

   // watchdog on cycles without any transaction, and the final verdict
   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d answers pending",
                     idle_cycles, answer_queue.size());
            $display("*** FAILED ***");
            $finish;
         end
         if (stim_done && answer_queue.size() == 0) begin
            // drain: anything arriving now is flagged as unexpected
            repeat (50) @(posedge clock);
            $display("ran %0d queries: directed corners plus random boards,", answers_seen);
            $display("%0d reachable, with sender gaps and receiver stalls", reach_seen);
            if (error_count == 0) $display("*** PASSED ***");
            else $display("*** FAILED ***");
            $finish;
         end
      end
   end

endmodule

// ----- knight_shortest_path_bfs.f -----
sv/ksp_pkg.sv
sv/ksp_if.sv
sv/ksp_ram.sv
sv/knight_shortest_path_bfs.sv
verif/tb_knight_shortest_path_bfs.sv
